### sv/npct_pkg.sv
// Shared types and constants for the narrow-phase collision pipeline.
// Used by the square root cell, the divider cell and the top level.
`default_nettype none
package npct_pkg;

	localparam int CoordBits = 24;
	localparam int SizeBits  = 23;
	localparam int MagBits   = 25;
	localparam int RootBits  = 32;
	localparam int RadBits   = 35;
	localparam int QuoBits   = 15;
	localparam int DivBits   = 48;

	typedef enum logic [1:0] {
		MODE_RR = 2'd0,
		MODE_CC = 2'd1,
		MODE_RC = 2'd2,
		MODE_CR = 2'd3
	} mode_t;

	// Everything an item drags along beside the square root and the divider.
	typedef struct packed {
		mode_t                  mode;
		logic                   r_hit;
		logic signed [15:0]     r_nx;
		logic signed [15:0]     r_ny;
		logic signed [23:0]     r_px;
		logic signed [23:0]     r_py;
		logic                   c_hit;
		logic                   c_zero;
		logic                   sx;
		logic                   sy;
		logic [MagBits-1:0]     mx;
		logic [MagBits-1:0]     my;
		logic [CoordBits-1:0]   rad;
		logic [RootBits-1:0]    depth;
	} side_t;

endpackage
`default_nettype wire

### sv/narrow_phase_collision_test_top.sv
// Narrow-phase collision test, top level: front stages, cell chains, output skid.
// Depends on npct_pkg, npct_sqrt_cell and npct_div_cell.
//
// Usage: each slave-side transaction carries one shape pair and a pair mode
// (rect-rect, circle-circle, rect-circle, circle-rect). Each master-side
// transaction carries one result: hit flag, Q1.14 contact normal and a
// saturated penetration vector, Q15.8 for pairs with a circle and whole
// units for rect-rect. Results leave in the order pairs came in. Throughput
// is one pair per clock while s_tready is high. A pair passes five front
// stages (input register, operand select and overlaps, least overlap and
// clamp, squares, distance compare), 32 square root cells that settle one
// root bit each, one divider setup stage, 15 divider cells that settle one
// quotient bit each for x and y, two finishing stages and the output register.
// Reset clears every valid bit; no pair survives it and no setup pass follows.
// When the receiver stalls, one more result is caught in a skid register and
// then s_tready falls, freezing the whole pipeline until the skid drains.
// s_tready is the inverse of the skid valid register.
`default_nettype none
module narrow_phase_collision_test_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cmd[1:0], a_x[25:2], a_y[49:26], a_w[72:50], a_h[95:73],
	// b_x[119:96], b_y[143:120], b_w[166:144], b_h[189:167], zero pad above
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit[0], normal_x[16:1], normal_y[32:17], pen_x[56:33], pen_y[80:57], zero pad
	output logic [87:0]  m_tdata
);
	import npct_pkg::*;

	localparam int SqrtCells = RootBits;
	localparam int DivCells  = QuoBits;

	typedef struct packed {
		logic signed [23:0] py;
		logic signed [23:0] px;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
		logic               hit;
	} res_t;

	function automatic logic signed [23:0] sat_pos(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v > 26'sd8388607) begin
			r = 24'sd8388607;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	logic en;
	logic skid_v_q;
	logic out_v_q;
	res_t out_q;
	res_t skid_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// Stage 1: input register.
	logic                 v_s1;
	mode_t                cmd_s1;
	logic signed [23:0]   ax_s1, ay_s1, bx_s1, by_s1;
	logic [SizeBits-1:0]  aw_s1, ah_s1, bw_s1, bh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= mode_t'(s_tdata[1:0]);
			ax_s1  <= s_tdata[25:2];
			ay_s1  <= s_tdata[49:26];
			aw_s1  <= s_tdata[72:50];
			ah_s1  <= s_tdata[95:73];
			bx_s1  <= s_tdata[119:96];
			by_s1  <= s_tdata[143:120];
			bw_s1  <= s_tdata[166:144];
			bh_s1  <= s_tdata[189:167];
		end
	end

	// Stage 2: side overlaps for rect pairs, operand choice for circle pairs.
	// A circle pair is a circle against a rectangle of zero size.
	logic signed [25:0] ax26, ay26, bx26, by26;
	logic signed [25:0] pl_c, pr_c, pt_c, pb_c;
	logic signed [23:0] rx_c, ry_c, cx_c, cy_c;
	logic [SizeBits-1:0] rw_c, rh_c;
	logic [CoordBits-1:0] rad_c;

	always_comb begin
		ax26 = {{2{ax_s1[23]}}, ax_s1};
		ay26 = {{2{ay_s1[23]}}, ay_s1};
		bx26 = {{2{bx_s1[23]}}, bx_s1};
		by26 = {{2{by_s1[23]}}, by_s1};
		pl_c = ax26 + $signed({3'b000, aw_s1}) - bx26;
		pr_c = bx26 + $signed({3'b000, bw_s1}) - ax26;
		pt_c = ay26 + $signed({3'b000, ah_s1}) - by26;
		pb_c = by26 + $signed({3'b000, bh_s1}) - ay26;
		case (cmd_s1)
			MODE_RC: begin
				rx_c = ax_s1; ry_c = ay_s1; rw_c = aw_s1; rh_c = ah_s1;
				cx_c = bx_s1; cy_c = by_s1; rad_c = {1'b0, bw_s1};
			end
			MODE_CR: begin
				rx_c = bx_s1; ry_c = by_s1; rw_c = bw_s1; rh_c = bh_s1;
				cx_c = ax_s1; cy_c = ay_s1; rad_c = {1'b0, aw_s1};
			end
			default: begin
				rx_c = ax_s1; ry_c = ay_s1; rw_c = '0; rh_c = '0;
				cx_c = bx_s1; cy_c = by_s1;
				rad_c = CoordBits'({1'b0, aw_s1} + {1'b0, bw_s1});
			end
		endcase
	end

	logic                 v_s2;
	mode_t                cmd_s2;
	logic signed [25:0]   pl_s2, pr_s2, pt_s2, pb_s2;
	logic signed [25:0]   rx_s2, ry_s2, rr_s2, rb_s2, cx_s2, cy_s2;
	logic [CoordBits-1:0] rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			pl_s2  <= pl_c;
			pr_s2  <= pr_c;
			pt_s2  <= pt_c;
			pb_s2  <= pb_c;
			rx_s2  <= {{2{rx_c[23]}}, rx_c};
			ry_s2  <= {{2{ry_c[23]}}, ry_c};
			rr_s2  <= {{2{rx_c[23]}}, rx_c} + $signed({3'b000, rw_c});
			rb_s2  <= {{2{ry_c[23]}}, ry_c} + $signed({3'b000, rh_c});
			cx_s2  <= {{2{cx_c[23]}}, cx_c};
			cy_s2  <= {{2{cy_c[23]}}, cy_c};
			rad_s2 <= rad_c;
		end
	end

	// Stage 3: least side overlap (ties go left, right, top, bottom) and the
	// offset from the nearest rectangle point to the circle centre.
	side_t               side_c3;
	logic signed [25:0]  dx_c, dy_c;

	always_comb begin
		side_c3 = '0;
		side_c3.mode  = cmd_s2;
		side_c3.rad   = rad_s2;
		side_c3.r_hit = (pl_s2 > 26'sd0) && (pr_s2 > 26'sd0) &&
			(pt_s2 > 26'sd0) && (pb_s2 > 26'sd0);
		if (side_c3.r_hit) begin
			if (pl_s2 <= pr_s2 && pl_s2 <= pt_s2 && pl_s2 <= pb_s2) begin
				side_c3.r_nx = -16'sd16384;
				side_c3.r_px = sat_pos(pl_s2);
			end else if (pr_s2 <= pt_s2 && pr_s2 <= pb_s2) begin
				side_c3.r_nx = 16'sd16384;
				side_c3.r_px = sat_pos(pr_s2);
			end else if (pt_s2 <= pb_s2) begin
				side_c3.r_ny = -16'sd16384;
				side_c3.r_py = sat_pos(pt_s2);
			end else begin
				side_c3.r_ny = 16'sd16384;
				side_c3.r_py = sat_pos(pb_s2);
			end
		end
		if (cx_s2 < rx_s2) begin
			dx_c = cx_s2 - rx_s2;
		end else if (cx_s2 > rr_s2) begin
			dx_c = cx_s2 - rr_s2;
		end else begin
			dx_c = '0;
		end
		if (cy_s2 < ry_s2) begin
			dy_c = cy_s2 - ry_s2;
		end else if (cy_s2 > rb_s2) begin
			dy_c = cy_s2 - rb_s2;
		end else begin
			dy_c = '0;
		end
		side_c3.sx = dx_c[25];
		side_c3.sy = dy_c[25];
		side_c3.mx = dx_c[25] ? MagBits'(-dx_c) : dx_c[MagBits-1:0];
		side_c3.my = dy_c[25] ? MagBits'(-dy_c) : dy_c[MagBits-1:0];
	end

	logic  v_s3;
	side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_c3;
		end
	end

	// Stage 4: squares.
	logic        v_s4;
	side_t       side_s4;
	logic [49:0] dxsq_s4, dysq_s4;
	logic [47:0] radsq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4  <= side_s3;
			dxsq_s4  <= side_s3.mx * side_s3.mx;
			dysq_s4  <= side_s3.my * side_s3.my;
			radsq_s4 <= side_s3.rad * side_s3.rad;
		end
	end

	// Stage 5: squared distance and the hit test. A hit keeps it below 2^48,
	// so the radicand with 16 extra fraction bits fits 64 bits.
	logic [50:0] dsq_c;
	side_t       side_c5;

	always_comb begin
		dsq_c = {1'b0, dxsq_s4} + {1'b0, dysq_s4};
		side_c5        = side_s4;
		side_c5.c_hit  = dsq_c < {3'b000, radsq_s4};
		side_c5.c_zero = (dsq_c == '0);
	end

	logic        sv_c [0:SqrtCells];
	logic [63:0] sn_c [0:SqrtCells];
	logic [33:0] sr_c [0:SqrtCells];
	logic [31:0] sq_c [0:SqrtCells];
	side_t       ss_c [0:SqrtCells];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_c[0] <= 1'b0;
		end else if (en) begin
			sv_c[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_c[0] <= {dsq_c[47:0], 16'h0000};
			sr_c[0] <= '0;
			sq_c[0] <= '0;
			ss_c[0] <= side_c5;
		end
	end

	for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
		npct_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (sv_c[i]),
			.n_in     (sn_c[i]),
			.r_in     (sr_c[i]),
			.root_in  (sq_c[i]),
			.side_in  (ss_c[i]),
			.v_out    (sv_c[i+1]),
			.n_out    (sn_c[i+1]),
			.r_out    (sr_c[i+1]),
			.root_out (sq_c[i+1]),
			.side_out (ss_c[i+1])
		);
	end

	// Divider setup: rounded numerators, shifted divisor and circle depth.
	logic               dv_c  [0:DivCells];
	logic [DivBits-1:0] dd_c  [0:DivCells];
	logic [DivBits-1:0] drx_c [0:DivCells];
	logic [DivBits-1:0] dry_c [0:DivCells];
	logic [QuoBits-1:0] dqx_c [0:DivCells];
	logic [QuoBits-1:0] dqy_c [0:DivCells];
	side_t              ds_c  [0:DivCells];
	side_t              side_sd;
	logic [31:0]        root_sd;

	always_comb begin
		root_sd       = sq_c[SqrtCells];
		side_sd       = ss_c[SqrtCells];
		side_sd.depth = {side_sd.rad, 8'h00} - root_sd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_c[0] <= 1'b0;
		end else if (en) begin
			dv_c[0] <= sv_c[SqrtCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_c[0]  <= {2'b00, root_sd, 14'h0000};
			drx_c[0] <= {1'b0, side_sd.mx, 22'h000000} + {17'h00000, root_sd[31:1]};
			dry_c[0] <= {1'b0, side_sd.my, 22'h000000} + {17'h00000, root_sd[31:1]};
			dqx_c[0] <= '0;
			dqy_c[0] <= '0;
			ds_c[0]  <= side_sd;
		end
	end

	for (genvar j = 0; j < DivCells; j++) begin : g_div
		npct_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (dv_c[j]),
			.ds_in    (dd_c[j]),
			.remx_in  (drx_c[j]),
			.remy_in  (dry_c[j]),
			.qx_in    (dqx_c[j]),
			.qy_in    (dqy_c[j]),
			.side_in  (ds_c[j]),
			.v_out    (dv_c[j+1]),
			.ds_out   (dd_c[j+1]),
			.remx_out (drx_c[j+1]),
			.remy_out (dry_c[j+1]),
			.qx_out   (dqx_c[j+1]),
			.qy_out   (dqy_c[j+1]),
			.side_out (ds_c[j+1])
		);
	end

	// Finish 1: signed normals and depth times normal magnitude.
	logic               v_p1;
	side_t              side_p1;
	logic signed [15:0] nx_p1, ny_p1;
	logic [46:0]        prx_p1, pry_p1;
	logic [QuoBits-1:0] qx_f, qy_f;

	assign qx_f = dqx_c[DivCells];
	assign qy_f = dqy_c[DivCells];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
		end else if (en) begin
			v_p1 <= dv_c[DivCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_p1 <= ds_c[DivCells];
			nx_p1   <= ds_c[DivCells].sx ? -$signed({1'b0, qx_f}) : $signed({1'b0, qx_f});
			ny_p1   <= ds_c[DivCells].sy ? -$signed({1'b0, qy_f}) : $signed({1'b0, qy_f});
			prx_p1  <= ds_c[DivCells].depth * qx_f;
			pry_p1  <= ds_c[DivCells].depth * qy_f;
		end
	end

	// Finish 2: round, saturate, sign, and pick the result for the mode.
	function automatic logic signed [23:0] pen_sat(input logic [46:0] prod,
		input logic neg);
		logic [47:0] sum;
		logic [25:0] mag;
		logic signed [23:0] r;
		sum = {1'b0, prod} + 48'h0000_0020_0000;
		mag = sum[47:22];
		if (neg) begin
			r = (mag > 26'd8388608) ? -24'sd8388608 : 24'(-$signed({1'b0, mag}));
		end else begin
			r = (mag > 26'd8388607) ? 24'sd8388607 : mag[23:0];
		end
		return r;
	endfunction

	res_t res_c;

	always_comb begin
		res_c = '0;
		if (side_p1.mode == MODE_RR) begin
			res_c.hit = side_p1.r_hit;
			res_c.nx  = side_p1.r_nx;
			res_c.ny  = side_p1.r_ny;
			res_c.px  = side_p1.r_px;
			res_c.py  = side_p1.r_py;
		end else begin
			res_c.hit = side_p1.c_hit;
			if (side_p1.c_hit && !side_p1.c_zero) begin
				res_c.nx = (side_p1.mode == MODE_CR) ? -nx_p1 : nx_p1;
				res_c.ny = (side_p1.mode == MODE_CR) ? -ny_p1 : ny_p1;
				res_c.px = pen_sat(prx_p1, side_p1.sx);
				res_c.py = pen_sat(pry_p1, side_p1.sy);
			end
		end
	end

	logic v_p2;
	res_t res_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p2 <= 1'b0;
		end else if (en) begin
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_p2 <= res_c;
		end
	end

	// Output register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_tready) begin
			if (!skid_v_q) begin
				skid_v_q <= v_p2;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_tready) begin
			if (!skid_v_q) begin
				skid_q <= res_p2;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res_p2;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'h00, out_q};

endmodule
`default_nettype wire

### sv/npct_sqrt_cell.sv
// Integer square root cell: one root bit per cycle while en is high.
// Depends on npct_pkg for the side data type.
`default_nettype none
module npct_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  logic [63:0]         n_in,
	input  logic [33:0]         r_in,
	input  logic [31:0]         root_in,
	input  npct_pkg::side_t     side_in,
	output logic                v_out,
	output logic [63:0]         n_out,
	output logic [33:0]         r_out,
	output logic [31:0]         root_out,
	output npct_pkg::side_t     side_out
);
	import npct_pkg::*;

	logic [34:0] rs;
	logic [34:0] trial;
	logic        take;

	always_comb begin
		rs    = {r_in[32:0], n_in[63:62]};
		trial = {1'b0, root_in, 2'b01};
		take  = (rs >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_out    <= {n_in[61:0], 2'b00};
			r_out    <= take ? 34'(rs - trial) : rs[33:0];
			root_out <= {root_in[30:0], take};
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

### sv/npct_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for x and y.
// Depends on npct_pkg for widths and the side data type.
`default_nettype none
module npct_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  logic [npct_pkg::DivBits-1:0] ds_in,
	input  logic [npct_pkg::DivBits-1:0] remx_in,
	input  logic [npct_pkg::DivBits-1:0] remy_in,
	input  logic [npct_pkg::QuoBits-1:0] qx_in,
	input  logic [npct_pkg::QuoBits-1:0] qy_in,
	input  npct_pkg::side_t             side_in,
	output logic                        v_out,
	output logic [npct_pkg::DivBits-1:0] ds_out,
	output logic [npct_pkg::DivBits-1:0] remx_out,
	output logic [npct_pkg::DivBits-1:0] remy_out,
	output logic [npct_pkg::QuoBits-1:0] qx_out,
	output logic [npct_pkg::QuoBits-1:0] qy_out,
	output npct_pkg::side_t             side_out
);
	import npct_pkg::*;

	logic gex;
	logic gey;

	always_comb begin
		gex = (remx_in >= ds_in);
		gey = (remy_in >= ds_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_out   <= {1'b0, ds_in[DivBits-1:1]};
			remx_out <= gex ? remx_in - ds_in : remx_in;
			remy_out <= gey ? remy_in - ds_in : remy_in;
			qx_out   <= {qx_in[QuoBits-2:0], gex};
			qy_out   <= {qy_in[QuoBits-2:0], gey};
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

### verif/narrow_phase_collision_test_top_tb.sv
// Self-checking testbench for the narrow-phase collision pipeline.
// Depends on npct_pkg and narrow_phase_collision_test_top; needs nothing else.
// Pairs are sent in bursts while the result side stalls, and every result is
// compared with a local contact model.
`timescale 1ns / 1ps
`default_nettype none
module narrow_phase_collision_test_top_tb;
	import npct_pkg::*;

	// Generous cycle budget: about 620 pairs, the full pipeline depth, a receiver
	// that can stall most cycles and random sender gaps between bursts.
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 80;
	localparam longint CoordMax = (64'sd1 <<< 23) - 1;
	localparam longint CoordMin = -(64'sd1 <<< 23);
	localparam longint NormOne = 16384;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [23:0] px;
		logic signed [23:0] py;
	} contact_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [87:0]  m_tdata;

	contact_t expected_contacts[$];
	int       mismatches;
	int       pairs_sent;
	int       contacts_checked;
	int       hits_seen;
	int       cycle_count;
	int       burst_left;

	narrow_phase_collision_test_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------------
	// Contact model. All arithmetic is exact on 64- or 128-bit integers.
	// ---------------------------------------------------------------------
	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Division rounded half away from zero; the divisor is always positive.
	function automatic longint div_round(longint n, longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	// Integer square root of a value that fits in 94 bits; the root fits in 47.
	function automatic longint isqrt(logic [127:0] n);
		logic [127:0] root;
		logic [127:0] trial;
		root = '0;
		for (int b = 46; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return longint'(root[63:0]);
	endfunction

	// Round contact between a point offset (dx, dy) and a circle of radius rad.
	function automatic contact_t round_contact(longint dx, longint dy, longint rad);
		contact_t     c;
		logic [127:0] dist_sq;
		logic [127:0] rad_sq;
		longint       root_len;
		longint       nx;
		longint       ny;
		longint       depth;
		c = '0;
		dist_sq = 128'(dx * dx) + 128'(dy * dy);
		rad_sq = 128'(rad * rad);
		if (dist_sq >= rad_sq)
			return c;
		c.hit = 1'b1;
		// Coincident centres (or centre on the rectangle) hit with no direction.
		if (dist_sq == 0)
			return c;
		root_len = isqrt(dist_sq << 16);
		nx = clamp_to(div_round(dx * (64'sd1 <<< 22), root_len), -NormOne, NormOne);
		ny = clamp_to(div_round(dy * (64'sd1 <<< 22), root_len), -NormOne, NormOne);
		depth = rad * 256 - root_len;
		c.nx = 16'(nx);
		c.ny = 16'(ny);
		c.px = 24'(clamp_to(div_round(depth * nx, 64'sd1 <<< 22), CoordMin, CoordMax));
		c.py = 24'(clamp_to(div_round(depth * ny, 64'sd1 <<< 22), CoordMin, CoordMax));
		return c;
	endfunction

	function automatic contact_t rect_circle_contact(longint rx, longint ry, longint rw,
			longint rh, longint cx, longint cy, longint cr);
		longint qx;
		longint qy;
		qx = clamp_to(cx, rx, rx + rw);
		qy = clamp_to(cy, ry, ry + rh);
		return round_contact(cx - qx, cy - qy, cr);
	endfunction

	function automatic contact_t rect_rect_contact(longint ax, longint ay, longint aw,
			longint ah, longint bx, longint by, longint bw, longint bh);
		contact_t c;
		longint   ol;
		longint   orr;
		longint   ot;
		longint   ob;
		longint   least;
		c = '0;
		ol = ax + aw - bx;
		orr = bx + bw - ax;
		ot = ay + ah - by;
		ob = by + bh - ay;
		// Strict compares: rectangles that only touch do not overlap.
		if (!(ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by))
			return c;
		c.hit = 1'b1;
		least = ol;
		if (orr < least) least = orr;
		if (ot < least) least = ot;
		if (ob < least) least = ob;
		// Ties resolve left, right, top, bottom.
		if (least == ol) begin
			c.nx = -16'(NormOne);
			c.px = 24'(clamp_to(ol, CoordMin, CoordMax));
		end else if (least == orr) begin
			c.nx = 16'(NormOne);
			c.px = 24'(clamp_to(orr, CoordMin, CoordMax));
		end else if (least == ot) begin
			c.ny = -16'(NormOne);
			c.py = 24'(clamp_to(ot, CoordMin, CoordMax));
		end else begin
			c.ny = 16'(NormOne);
			c.py = 24'(clamp_to(ob, CoordMin, CoordMax));
		end
		return c;
	endfunction

	function automatic contact_t predict_contact(logic [191:0] d);
		contact_t c;
		mode_t    mode;
		longint   ax;
		longint   ay;
		longint   aw;
		longint   ah;
		longint   bx;
		longint   by;
		longint   bw;
		longint   bh;
		mode = mode_t'(d[1:0]);
		ax = longint'($signed(d[25:2]));
		ay = longint'($signed(d[49:26]));
		aw = longint'({1'b0, d[72:50]});
		ah = longint'({1'b0, d[95:73]});
		bx = longint'($signed(d[119:96]));
		by = longint'($signed(d[143:120]));
		bw = longint'({1'b0, d[166:144]});
		bh = longint'({1'b0, d[189:167]});
		case (mode)
			MODE_RR: c = rect_rect_contact(ax, ay, aw, ah, bx, by, bw, bh);
			MODE_CC: c = round_contact(bx - ax, by - ay, aw + bw);
			MODE_RC: c = rect_circle_contact(ax, ay, aw, ah, bx, by, bw);
			default: begin
				// Circle against rectangle: operands swap and only the normal flips.
				c = rect_circle_contact(bx, by, bw, bh, ax, ay, aw);
				c.nx = -c.nx;
				c.ny = -c.ny;
			end
		endcase
		return c;
	endfunction

	// ---------------------------------------------------------------------
	// Checking.
	// ---------------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= 30)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Predictions are made on the edge where a pair is accepted, and results
	// are checked on the edge where they are taken. Both sample values from
	// before the edge, so the pipeline's own updates cannot race them.
	always @(posedge clk) begin
		contact_t want;
		contact_t got;
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, expected_contacts.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_contacts = {expected_contacts, predict_contact(s_tdata)};
			if (m_tvalid && m_tready) begin
				got = '{hit: m_tdata[0], nx: m_tdata[16:1], ny: m_tdata[32:17],
					px: m_tdata[56:33], py: m_tdata[80:57]};
				if (expected_contacts.size() == 0) begin
					report_mismatch("unexpected result transaction", 1, 0);
				end else begin
					want = expected_contacts.pop_front();
					contacts_checked++;
					if (want.hit)
						hits_seen++;
					if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
					if (got.nx !== want.nx) report_mismatch("normal_x", got.nx, want.nx);
					if (got.ny !== want.ny) report_mismatch("normal_y", got.ny, want.ny);
					if (got.px !== want.px) report_mismatch("pen_x", got.px, want.px);
					if (got.py !== want.py) report_mismatch("pen_y", got.py, want.py);
					if (m_tdata[87:81] !== '0) report_mismatch("pad bits", m_tdata[87:81], 0);
				end
			end
		end
	end

	// The receiver steps through four stall habits in turn: always ready,
	// mostly ready, a fixed 5-of-8 pattern, and mostly stalled.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			case ((cycle_count / 300) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 9) < 7);
				2: m_tready <= ((cycle_count % 8) < 5);
				default: m_tready <= ($urandom_range(0, 9) < 2);
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus.
	// ---------------------------------------------------------------------
	function automatic logic [191:0] pack_pair(mode_t mode, longint ax, longint ay,
			longint aw, longint ah, longint bx, longint by, longint bw, longint bh);
		logic [191:0] d;
		d = '0;
		d[1:0] = mode;
		d[25:2] = 24'(ax);
		d[49:26] = 24'(ay);
		d[72:50] = 23'(aw);
		d[95:73] = 23'(ah);
		d[119:96] = 24'(bx);
		d[143:120] = 24'(by);
		d[166:144] = 23'(bw);
		d[189:167] = 23'(bh);
		return d;
	endfunction

	// Sends one pair. Within a burst valid stays high and only the data moves;
	// when a burst ends, valid drops for a random gap.
	task automatic send_pair(logic [191:0] d);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		pairs_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 20);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic test_rect_pairs_directed();
		// Identical rectangles: all four overlaps tie and left wins.
		send_pair(pack_pair(MODE_RR, 0, 0, 256, 256, 0, 0, 256, 256));
		// Right, top and bottom overlap each the smallest in turn.
		send_pair(pack_pair(MODE_RR, 100, 0, 100, 400, 0, 0, 150, 400));
		send_pair(pack_pair(MODE_RR, 0, 0, 400, 100, 0, 80, 400, 400));
		send_pair(pack_pair(MODE_RR, 0, 100, 400, 100, 0, 0, 400, 150));
		// Edges that only touch, and zero-size rectangles.
		send_pair(pack_pair(MODE_RR, 0, 0, 256, 256, 256, 0, 256, 256));
		send_pair(pack_pair(MODE_RR, 0, 0, 256, 256, 0, -256, 256, 256));
		send_pair(pack_pair(MODE_RR, 10, 10, 0, 0, 0, 0, 100, 100));
		// Extreme corners and sizes, where overlaps overflow the coordinate range.
		send_pair(pack_pair(MODE_RR, CoordMin, CoordMin, 23'h7fffff, 23'h7fffff,
			CoordMin, CoordMin, 23'h7fffff, 23'h7fffff));
		send_pair(pack_pair(MODE_RR, CoordMax, CoordMax, 23'h7fffff, 23'h7fffff,
			CoordMin, CoordMin, 23'h7fffff, 23'h7fffff));
		send_pair(pack_pair(MODE_RR, -1000, -1000, 23'h7fffff, 23'h7fffff,
			-2000, -2000, 23'h7fffff, 23'h7fffff));
	endtask

	task automatic test_circle_pairs_directed();
		// Coincident centres hit with zero normal and penetration.
		send_pair(pack_pair(MODE_CC, 500, -500, 300, 0, 500, -500, 200, 0));
		// Zero radii never hit, even when coincident.
		send_pair(pack_pair(MODE_CC, 0, 0, 0, 0, 0, 0, 0, 0));
		// Touching circles, a diagonal hit and an axis hit.
		send_pair(pack_pair(MODE_CC, 0, 0, 256, 0, 512, 0, 256, 0));
		send_pair(pack_pair(MODE_CC, 0, 0, 300, 0, 200, -150, 100, 0));
		send_pair(pack_pair(MODE_CC, CoordMin, CoordMax, 23'h7fffff, 23'h7fffff,
			CoordMax, CoordMin, 23'h7fffff, 23'h7fffff));
		send_pair(pack_pair(MODE_CC, CoordMax, CoordMax, 23'h7fffff, 0,
			CoordMax - 1, CoordMax, 23'h7fffff, 0));
		// Rectangle against circle: centre inside, near a corner, beside a side.
		send_pair(pack_pair(MODE_RC, 0, 0, 1000, 1000, 500, 500, 100, 0));
		send_pair(pack_pair(MODE_RC, 0, 0, 1000, 1000, 1050, 1060, 100, 0));
		send_pair(pack_pair(MODE_RC, 0, 0, 1000, 1000, -70, 400, 100, 0));
		send_pair(pack_pair(MODE_RC, 0, 0, 1000, 1000, 1100, 400, 100, 0));
		// Circle against rectangle: the same shapes with the normal flipped.
		send_pair(pack_pair(MODE_CR, 1050, 1060, 100, 23'h7fffff, 0, 0, 1000, 1000));
		send_pair(pack_pair(MODE_CR, -70, 400, 100, 0, 0, 0, 1000, 1000));
		send_pair(pack_pair(MODE_CR, CoordMin, CoordMin, 23'h7fffff, 23'h7fffff,
			CoordMax, CoordMax, 23'h7fffff, 23'h7fffff));
	endtask

	// Most pairs sit close together so hits and every winning side are common;
	// a tenth use fully random fields so every bit toggles.
	task automatic test_random_pairs(int count);
		longint base_x;
		longint base_y;
		longint span;
		longint size;
		mode_t  mode;
		for (int i = 0; i < count; i++) begin
			mode = mode_t'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				send_pair(pack_pair(mode, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
			end else begin
				span = ($urandom_range(0, 3) == 0) ? 65535 : 2047;
				size = ($urandom_range(0, 7) == 0) ? 23'h7fffff : span;
				base_x = longint'($signed(24'($urandom)));
				base_y = longint'($signed(24'($urandom)));
				send_pair(pack_pair(mode,
					base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
					$urandom_range(0, size), $urandom_range(0, size),
					base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
					$urandom_range(0, size), $urandom_range(0, size)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		pairs_sent = 0;
		contacts_checked = 0;
		hits_seen = 0;
		cycle_count = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_rect_pairs_directed();
		test_circle_pairs_directed();
		test_random_pairs(600);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_contacts.size() != 0)
			@(posedge clk);
		// Any result beyond the last expected one would show up here.
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d shape pairs over all four pair modes; checked %0d results, %0d hits.",
			pairs_sent, contacts_checked, hits_seen);
		$display("Field mismatches found: %0d.", mismatches);
		if (mismatches == 0 && expected_contacts.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire

### narrow_phase_collision_test_top.f
sv/npct_pkg.sv
sv/npct_sqrt_cell.sv
sv/npct_div_cell.sv
sv/narrow_phase_collision_test_top.sv
verif/narrow_phase_collision_test_top_tb.sv
